// File: hw/rtl/jddc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddc_pkg
// shared types, codes and helpers for the differential drive mixer
// ----------------------------------------------------------------------------
package jddc_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_DEADZONE      = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE_MS   = 2'd1;
  localparam logic [1:0] REG_FLIPPER_ANGLE = 2'd2;

  // configuration reset values
  localparam logic [6:0]  DEADZONE_RST      = 7'd10;
  localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd100;
  localparam logic [6:0]  FLIPPER_ANGLE_RST = 7'd60;

  // motor direction codes (2-bit two's complement)
  localparam logic [1:0] DIR_STOP = 2'b00;
  localparam logic [1:0] DIR_FWD  = 2'b01;
  localparam logic [1:0] DIR_REV  = 2'b11;

  localparam logic [7:0] FULL_DUTY = 8'd255;
  localparam logic [7:0] SERVO_MID = 8'd90;

  // request to the shared multiply / compare unit
  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  b;
    logic [15:0] cmp;
  } alu_req_t;

  // response of the shared unit
  typedef struct packed {
    logic [15:0] prod;
    logic        fits;  // prod <= cmp
    logic [7:0]  sat;   // prod >> 7, clipped at full duty
  } alu_rsp_t;

  // axis magnitude 0..128 to duty 0..255: mag * 255 / 128
  function automatic logic [7:0] map_axis(input logic [7:0] mag);
    logic [15:0] t;
    t = {mag, 8'b0} - {8'b0, mag};
    return t[14:7];
  endfunction

endpackage

// File: hw/rtl/jddc_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddc_alu
// shared 8x8 multiplier with compare and duty saturation
// ----------------------------------------------------------------------------
module jddc_alu import jddc_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [15:0] prod;

  assign prod     = req.a * req.b;
  assign rsp.prod = prod;
  assign rsp.fits = (prod <= req.cmp);
  // values of 2^15 and up exceed 255 after the shift
  assign rsp.sat  = prod[15] ? FULL_DUTY : prod[14:7];

endmodule

// File: hw/rtl/joystick_differential_drive_control_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_differential_drive_control_core
// arcade-drive mixer: stick to two motor commands, drum and flipper toggles,
// emergency stop latch and safety interlock
// ----------------------------------------------------------------------------
//
// channel   dir   handshake              payload
// in_*      in    in_valid / in_ready    link, buttons, stick x/y, now_ms
// out_*     out   out_valid / out_ready  motor dirs/powers, drum, servos, status
// cfg_*     in    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// after accept a transaction steps through the states in order: square
// and sum the axes, run the bitwise square root from the top bit down,
// scale the arc powers, register the result; all of it goes through the
// one shared multiplier
// reset (synchronous, active low) clears the stop, flipper and drum latches,
// sets the safety interlock and reloads the configuration defaults
// a stalled output holds the finished transaction; the next result waits
// in the final state until the output register frees up
// in_ready is high only while the sequencer is idle; cfg_ready is always high
//
module joystick_differential_drive_control_core import jddc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_link_up,
  input  logic        in_stop_button,
  input  logic signed [7:0] in_stick_y,
  input  logic signed [7:0] in_stick_x,
  input  logic        in_flip_button,
  input  logic        in_drum_button,
  input  logic        in_safety_button,
  input  logic [31:0] in_now_ms,

  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [1:0] out_left_dir,
  output logic [7:0]  out_left_power,
  output logic signed [1:0] out_right_dir,
  output logic [7:0]  out_right_power,
  output logic        out_drum_run,
  output logic [7:0]  out_servo_a_angle,
  output logic [7:0]  out_servo_b_angle,
  output logic        out_servo_update,
  output logic        out_estop_active,
  output logic        out_safety_on,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQX  = 3'd1;  // ax * ax
  localparam logic [2:0] S_SQY  = 3'd2;  // + ay * ay
  localparam logic [2:0] S_ROOT = 3'd3;  // one root bit per cycle
  localparam logic [2:0] S_SCL  = 3'd4;  // left power * magnitude
  localparam logic [2:0] S_SCR  = 3'd5;  // right power * magnitude
  localparam logic [2:0] S_DONE = 3'd6;  // load output register

  // configuration
  logic [6:0]  deadzone_r;
  logic [15:0] debounce_r;
  logic [6:0]  flip_angle_r;

  // persistent state
  logic        estop_r, estop_nxt;
  logic        safety_r, safety_nxt;
  logic        flipper_r, flipper_nxt;
  logic        drum_r, drum_nxt;
  logic [31:0] flip_time_r, flip_time_nxt;
  logic [31:0] drum_time_r, drum_time_nxt;

  // sequencer and working registers
  logic [2:0]  state_r, state_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  ax_r, ax_nxt;
  logic [7:0]  ay_r, ay_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  root_r, root_nxt;
  logic [7:0]  lbase_r, lbase_nxt;
  logic [7:0]  rbase_r, rbase_nxt;
  logic        arc_r, arc_nxt;
  logic        drive_r, drive_nxt;
  logic [1:0]  ld_r, ld_nxt;
  logic [1:0]  rd_r, rd_nxt;
  logic [7:0]  lp_r, lp_nxt;
  logic [7:0]  rp_r, rp_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic [1:0]  o_ld_r, o_rd_r;
  logic [7:0]  o_lp_r, o_rp_r, o_sa_r, o_sb_r;
  logic        o_drum_r, o_upd_r, o_estop_r, o_safety_r;

  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;

  logic        in_acc;
  logic        out_free;
  logic [7:0]  abs_x, abs_y;
  logic        xc, yc;
  logic [31:0] flip_el, drum_el;
  logic [7:0]  trial;
  logic [6:0]  servo_off;
  logic [7:0]  servo_a, servo_b;

  jddc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !ov_r || out_ready;

  // -128 wraps to 0x80, read as unsigned 128
  assign abs_x = in_stick_x[7] ? 8'(-in_stick_x) : in_stick_x;
  assign abs_y = in_stick_y[7] ? 8'(-in_stick_y) : in_stick_y;
  assign xc    = abs_x < {1'b0, deadzone_r};
  assign yc    = abs_y < {1'b0, deadzone_r};

  // elapsed time since last accepted toggle, modulo 2^32
  assign flip_el = in_now_ms - flip_time_r;
  assign drum_el = in_now_ms - drum_time_r;

  assign trial = root_r | (8'd1 << bit_r);

  // servo offset clipped at 90 degrees
  assign servo_off = (flip_angle_r > SERVO_MID[6:0]) ? SERVO_MID[6:0] : flip_angle_r;
  assign servo_a   = flipper_r ? SERVO_MID + {1'b0, servo_off} : SERVO_MID;
  assign servo_b   = flipper_r ? SERVO_MID - {1'b0, servo_off} : SERVO_MID;

  // shared unit operand select
  always_comb begin
    alu_req = '0;
    case (state_r)
      S_SQX: begin
        alu_req.a = ax_r;
        alu_req.b = ax_r;
      end
      S_SQY: begin
        alu_req.a = ay_r;
        alu_req.b = ay_r;
      end
      S_ROOT: begin
        alu_req.a   = trial;
        alu_req.b   = trial;
        alu_req.cmp = sum_r;
      end
      S_SCL: begin
        alu_req.a = lbase_r;
        alu_req.b = root_r;
      end
      S_SCR: begin
        alu_req.a = rbase_r;
        alu_req.b = root_r;
      end
      default: alu_req = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    bit_nxt       = bit_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    sum_nxt       = sum_r;
    root_nxt      = root_r;
    lbase_nxt     = lbase_r;
    rbase_nxt     = rbase_r;
    arc_nxt       = arc_r;
    drive_nxt     = drive_r;
    ld_nxt        = ld_r;
    rd_nxt        = rd_r;
    lp_nxt        = lp_r;
    rp_nxt        = rp_r;
    estop_nxt     = estop_r;
    safety_nxt    = safety_r;
    flipper_nxt   = flipper_r;
    drum_nxt      = drum_r;
    flip_time_nxt = flip_time_r;
    drum_time_nxt = drum_time_r;
    ov_nxt        = ov_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SQX;
          ax_nxt    = abs_x;
          ay_nxt    = abs_y;
          root_nxt  = '0;
          bit_nxt   = 3'd7;
          arc_nxt   = 1'b0;
          drive_nxt = 1'b0;
          ld_nxt    = DIR_STOP;
          rd_nxt    = DIR_STOP;
          lp_nxt    = '0;
          rp_nxt    = '0;
          // inner wheel of an arc runs at mapped |y|, outer at full duty
          if (in_stick_x > 8'sd0) begin
            lbase_nxt = FULL_DUTY;
            rbase_nxt = map_axis(abs_y);
          end else begin
            lbase_nxt = map_axis(abs_y);
            rbase_nxt = FULL_DUTY;
          end
          if (in_link_up) begin
            if (in_stop_button || estop_r) begin
              estop_nxt  = 1'b1;
              safety_nxt = 1'b1;
            end else begin
              if (in_flip_button && (flip_el > {16'b0, debounce_r})) begin
                flipper_nxt   = !flipper_r;
                flip_time_nxt = in_now_ms;
              end
              if (in_drum_button && (drum_el > {16'b0, debounce_r})) begin
                drum_nxt      = !drum_r;
                drum_time_nxt = in_now_ms;
              end
              if (yc && xc) begin
                ld_nxt = DIR_STOP;
                rd_nxt = DIR_STOP;
              end else if (yc) begin
                // spin in place
                ld_nxt = (in_stick_x > 8'sd0) ? DIR_FWD : DIR_REV;
                rd_nxt = (in_stick_x > 8'sd0) ? DIR_REV : DIR_FWD;
                lp_nxt = map_axis(abs_x);
                rp_nxt = map_axis(abs_x);
              end else if (xc) begin
                // straight, zero y counts as forward
                ld_nxt = in_stick_y[7] ? DIR_REV : DIR_FWD;
                rd_nxt = in_stick_y[7] ? DIR_REV : DIR_FWD;
                lp_nxt = map_axis(abs_y);
                rp_nxt = map_axis(abs_y);
              end else begin
                // arc, zero y counts as reverse
                arc_nxt = 1'b1;
                ld_nxt  = (in_stick_y > 8'sd0) ? DIR_FWD : DIR_REV;
                rd_nxt  = (in_stick_y > 8'sd0) ? DIR_FWD : DIR_REV;
              end
              safety_nxt = in_safety_button ? !safety_r : safety_r;
              drive_nxt  = in_safety_button ? safety_r : !safety_r;
            end
          end
        end
      end
      S_SQX: begin
        sum_nxt   = alu_rsp.prod;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        sum_nxt   = sum_r + alu_rsp.prod;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        // keep the trial bit when its square still fits
        if (alu_rsp.fits) begin
          root_nxt = trial;
        end
        if (bit_r == 3'd0) begin
          state_nxt = S_SCL;
        end else begin
          bit_nxt = bit_r - 3'd1;
        end
      end
      S_SCL: begin
        if (arc_r) begin
          lp_nxt = alu_rsp.sat;
        end
        state_nxt = S_SCR;
      end
      S_SCR: begin
        if (arc_r) begin
          rp_nxt = alu_rsp.sat;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ov_r         <= 1'b0;
      estop_r      <= 1'b0;
      safety_r     <= 1'b1;
      flipper_r    <= 1'b0;
      drum_r       <= 1'b0;
      flip_time_r  <= '0;
      drum_time_r  <= '0;
      deadzone_r   <= DEADZONE_RST;
      debounce_r   <= DEBOUNCE_MS_RST;
      flip_angle_r <= FLIPPER_ANGLE_RST;
    end else begin
      state_r     <= state_nxt;
      ov_r        <= ov_nxt;
      estop_r     <= estop_nxt;
      safety_r    <= safety_nxt;
      flipper_r   <= flipper_nxt;
      drum_r      <= drum_nxt;
      flip_time_r <= flip_time_nxt;
      drum_time_r <= drum_time_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEADZONE:      deadzone_r   <= cfg_data[6:0];
          REG_DEBOUNCE_MS:   debounce_r   <= cfg_data;
          REG_FLIPPER_ANGLE: flip_angle_r <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    bit_r   <= bit_nxt;
    ax_r    <= ax_nxt;
    ay_r    <= ay_nxt;
    sum_r   <= sum_nxt;
    root_r  <= root_nxt;
    lbase_r <= lbase_nxt;
    rbase_r <= rbase_nxt;
    ld_r    <= ld_nxt;
    rd_r    <= rd_nxt;
    lp_r    <= lp_nxt;
    rp_r    <= rp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arc_r   <= 1'b0;
      drive_r <= 1'b0;
    end else begin
      arc_r   <= arc_nxt;
      drive_r <= drive_nxt;
    end
  end

  // output register, drive fields masked when not driving
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      o_ld_r     <= drive_r ? ld_r : DIR_STOP;
      o_rd_r     <= drive_r ? rd_r : DIR_STOP;
      o_lp_r     <= drive_r ? lp_r : 8'd0;
      o_rp_r     <= drive_r ? rp_r : 8'd0;
      o_drum_r   <= drive_r && drum_r;
      o_sa_r     <= servo_a;
      o_sb_r     <= servo_b;
      o_upd_r    <= drive_r;
      o_estop_r  <= estop_r;
      o_safety_r <= safety_r;
    end
  end

  assign out_valid         = ov_r;
  assign out_left_dir      = o_ld_r;
  assign out_left_power    = o_lp_r;
  assign out_right_dir     = o_rd_r;
  assign out_right_power   = o_rp_r;
  assign out_drum_run      = o_drum_r;
  assign out_servo_a_angle = o_sa_r;
  assign out_servo_b_angle = o_sb_r;
  assign out_servo_update  = o_upd_r;
  assign out_estop_active  = o_estop_r;
  assign out_safety_on     = o_safety_r;

  // emergency stop stays latched until reset
  a_estop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    estop_r |=> estop_r)
    else $error("estop latch released");

  // a latched stop always keeps the interlock on
  a_estop_safety: assert property (@(posedge clk) disable iff (!rst_n)
    estop_r |-> safety_r)
    else $error("estop without safety");

  // no motor power in a result that reports the interlock on
  a_no_power_safe: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && (o_lp_r != 8'd0 || o_rp_r != 8'd0) |-> !o_safety_r && o_upd_r)
    else $error("motor power with safety on");

  // an accepted transaction starts the sequencer
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_SQX)
    else $error("sequencer did not start");

endmodule
